@@ src/bbe_pkg.sv @@
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types, character constants and small arithmetic helpers for the
// Bubble Babble encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bbe_pkg;

  // Character slots of one burst, in emit order
  localparam int NSLOT    = 11;
  localparam int SL_LEAD  = 0;   // leading 'x'
  localparam int SL_TUP   = 1;   // three-character tuple (1..3)
  localparam int SL_PAIR  = 4;   // consonant, '-', consonant (4..6)
  localparam int SL_TAIL  = 7;   // even-length tail tuple (7..9)
  localparam int SL_CLOSE = 10;  // closing 'x'

  localparam logic [7:0] CH_X    = 8'h78;  // 'x'
  localparam logic [7:0] CH_DASH = 8'h2d;  // '-'

  localparam logic [5:0] CHECK_INIT = 6'd1;

  typedef logic [NSLOT-1:0]      slot_mask_t;
  typedef logic [NSLOT-1:0][7:0] slot_chars_t;

  typedef struct packed {
    slot_mask_t  mask;
    slot_chars_t chars;
  } burst_t;

  function automatic logic [7:0] vowel(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h61;  // a
      3'd1:    ch = 8'h65;  // e
      3'd2:    ch = 8'h69;  // i
      3'd3:    ch = 8'h6f;  // o
      3'd4:    ch = 8'h75;  // u
      3'd5:    ch = 8'h79;  // y
      default: ch = 8'h61;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] cons(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h62;  // b
      4'd1:    ch = 8'h63;  // c
      4'd2:    ch = 8'h64;  // d
      4'd3:    ch = 8'h66;  // f
      4'd4:    ch = 8'h67;  // g
      4'd5:    ch = 8'h68;  // h
      4'd6:    ch = 8'h6b;  // k
      4'd7:    ch = 8'h6c;  // l
      4'd8:    ch = 8'h6d;  // m
      4'd9:    ch = 8'h6e;  // n
      4'd10:   ch = 8'h70;  // p
      4'd11:   ch = 8'h72;  // r
      4'd12:   ch = 8'h73;  // s
      4'd13:   ch = 8'h74;  // t
      4'd14:   ch = 8'h76;  // v
      default: ch = 8'h7a;  // z
    endcase
    return ch;
  endfunction

  // c / 6 for c in 0..35: (c * 43) >> 8
  function automatic logic [2:0] div6(input logic [5:0] c);
    logic [11:0] prod;
    prod = 12'(c) * 12'd43;
    return prod[10:8];
  endfunction

  function automatic logic [2:0] mod6(input logic [5:0] c);
    logic [5:0] q6;
    q6 = 6'(div6(c)) * 6'd6;
    return 3'(c - q6);
  endfunction

  // (a + m) mod 6 with a in 0..3 and m in 0..5
  function automatic logic [2:0] addmod6(input logic [1:0] a, input logic [2:0] m);
    logic [3:0] s;
    s = 4'(a) + 4'(m);
    if (s >= 4'd6) s = s - 4'd6;
    return s[2:0];
  endfunction

  // x mod 36 for x below 2216: quotient by reciprocal (1821 / 2^16)
  function automatic logic [5:0] mod36(input logic [11:0] x);
    logic [22:0] prod;
    logic [5:0]  q;
    logic [11:0] q36;
    prod = 23'(x) * 23'd1821;
    q    = prod[21:16];
    q36  = 12'(q) * 12'd36;
    return 6'(x - q36);
  endfunction

  function automatic logic [2:0][7:0] tuple(input logic [7:0] b, input logic [5:0] c);
    logic [2:0][7:0] t;
    t[0] = vowel(addmod6(b[7:6], mod6(c)));
    t[1] = cons(b[5:2]);
    t[2] = vowel(addmod6(b[1:0], div6(c)));
    return t;
  endfunction

endpackage

`default_nettype wire

@@ src/bubble_babble_encoder.sv @@
// ----------------------------------------------------------------------------
// bubble_babble_encoder
// Streams digest bytes in and Bubble Babble ASCII characters out.
// ----------------------------------------------------------------------------
// Each input item is one digest byte with a last-byte flag; each output item
// is one ASCII character, with out_last_char set on the closing 'x' of a
// message. The first byte of a message adds a leading 'x', every second byte
// releases six characters, and the last byte adds the closing tuple and 'x'
// (up to ten characters for one byte). An accepted byte is registered as a
// character burst; the output register then sends one character per cycle
// while out_stall is low, so the output side sets the rate. One burst waits
// behind the one being sent, so the next input byte can be taken while
// characters drain. Each burst passes through the burst register and the
// slot register before its characters reach the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bubble_babble_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_digest_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_last_char
);
  import bbe_pkg::*;

  burst_t burst;
  logic   burst_valid;
  logic   burst_take;

  bbe_encode u_encode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_digest_byte (in_digest_byte),
    .in_last_byte   (in_last_byte),
    .burst_o        (burst),
    .burst_valid_o  (burst_valid),
    .burst_take_i   (burst_take)
  );

  bbe_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .burst_i       (burst),
    .burst_valid_i (burst_valid),
    .burst_take_o  (burst_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

@@ src/bbe_encode.sv @@
// ----------------------------------------------------------------------------
// bbe_encode
// Takes one byte per item, keeps the message state and registers the
// burst of characters that the item produces.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_encode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_digest_byte,
  input  wire logic          in_last_byte,
  output bbe_pkg::burst_t    burst_o,
  output logic               burst_valid_o,
  input  wire logic          burst_take_i
);
  import bbe_pkg::*;

  logic [5:0]  check_r, check_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic        mid_r, mid_nxt;
  burst_t      burst_r, burst_nxt;
  logic        burst_valid_r, burst_valid_nxt;

  logic        accept;
  logic [7:0]  tup_byte;
  logic [11:0] sum;
  logic [5:0]  new_c;

  assign in_stall = burst_valid_r && !burst_take_i;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    tup_byte = held_v_r ? held_r : in_digest_byte;
    sum      = 12'(check_r) * 12'd5 + 12'(held_r) * 12'd7 + 12'(in_digest_byte);
    new_c    = mod36(sum);

    burst_nxt.chars[SL_LEAD]              = CH_X;
    burst_nxt.chars[SL_TUP+2:SL_TUP]      = tuple(tup_byte, check_r);
    burst_nxt.chars[SL_PAIR]              = cons(in_digest_byte[7:4]);
    burst_nxt.chars[SL_PAIR+1]            = CH_DASH;
    burst_nxt.chars[SL_PAIR+2]            = cons(in_digest_byte[3:0]);
    burst_nxt.chars[SL_TAIL]              = vowel(mod6(new_c));
    burst_nxt.chars[SL_TAIL+1]            = CH_X;
    burst_nxt.chars[SL_TAIL+2]            = vowel(div6(new_c));
    burst_nxt.chars[SL_CLOSE]             = CH_X;

    burst_nxt.mask                        = '0;
    burst_nxt.mask[SL_LEAD]               = !mid_r;
    burst_nxt.mask[SL_TUP+2:SL_TUP]       = {3{held_v_r || in_last_byte}};
    burst_nxt.mask[SL_PAIR+2:SL_PAIR]     = {3{held_v_r}};
    burst_nxt.mask[SL_TAIL+2:SL_TAIL]     = {3{held_v_r && in_last_byte}};
    burst_nxt.mask[SL_CLOSE]              = in_last_byte;

    check_nxt  = check_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    mid_nxt    = mid_r;
    if (accept) begin
      if (in_last_byte) begin
        check_nxt  = CHECK_INIT;
        held_v_nxt = 1'b0;
        mid_nxt    = 1'b0;
      end else begin
        mid_nxt = 1'b1;
        if (held_v_r) begin
          check_nxt  = new_c;
          held_v_nxt = 1'b0;
        end else begin
          held_nxt   = in_digest_byte;
          held_v_nxt = 1'b1;
        end
      end
    end

    // items that produce no character leave no burst behind
    if (accept) begin
      burst_valid_nxt = (burst_nxt.mask != '0);
    end else begin
      burst_valid_nxt = burst_valid_r && !burst_take_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r       <= CHECK_INIT;
      held_v_r      <= 1'b0;
      mid_r         <= 1'b0;
      burst_valid_r <= 1'b0;
    end else begin
      check_r       <= check_nxt;
      held_v_r      <= held_v_nxt;
      mid_r         <= mid_nxt;
      burst_valid_r <= burst_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (accept) begin
      burst_r <= burst_nxt;
    end
  end

  assign burst_o       = burst_r;
  assign burst_valid_o = burst_valid_r;

endmodule

`default_nettype wire

@@ src/bbe_serial.sv @@
// ----------------------------------------------------------------------------
// bbe_serial
// Walks the enabled slots of a burst, lowest first, and sends one
// character per cycle through the output register while it is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_serial (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bbe_pkg::burst_t burst_i,
  input  wire logic          burst_valid_i,
  output logic               burst_take_o,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_char,
  output logic               out_last_char
);
  import bbe_pkg::*;

  slot_mask_t  mask_r, mask_nxt;
  slot_chars_t chars_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r;
  logic        out_last_r;

  slot_mask_t  low_bit;
  slot_mask_t  mask_after;
  logic [7:0]  pick;
  logic        out_free;
  logic        advance;

  always_comb begin
    low_bit = mask_r & (~mask_r + slot_mask_t'(1));
    pick    = '0;
    for (int i = 0; i < NSLOT; i++) begin
      pick = pick | (chars_r[i] & {8{low_bit[i]}});
    end

    out_free   = !out_valid_r || !out_stall;
    advance    = (mask_r != '0) && out_free;
    mask_after = advance ? (mask_r & ~low_bit) : mask_r;

    // next burst loads as soon as the current one has been handed out
    burst_take_o = burst_valid_i && (mask_after == '0);
    mask_nxt     = burst_take_o ? burst_i.mask : mask_after;

    out_valid_nxt = out_free ? (mask_r != '0) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_take_o) begin
      chars_r <= burst_i.chars;
    end
    if (advance) begin
      out_char_r <= pick;
      out_last_r <= low_bit[SL_CLOSE];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

endmodule

`default_nettype wire

@@ src/bbe_checker.sv @@
// ----------------------------------------------------------------------------
// bbe_checker
// Port-level checks for the Bubble Babble encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       out_last_char
);
  import bbe_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last_char))
    else $error("output item changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // nothing is buffered after reset, so the input side is ready
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_close_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |-> out_char == CH_X)
    else $error("closing mark on a character other than x");

  // only lowercase letters and the dash ever leave the block
  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= 8'h61 && out_char <= 8'h7a) || out_char == CH_DASH)
    else $error("character outside the encoding alphabet");

endmodule

bind bubble_babble_encoder bbe_checker u_bbe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char       (out_char),
  .out_last_char  (out_last_char)
);

`default_nettype wire

@@ verif/bubble_babble_encoder_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bubble_babble_encoder_checker
// Watches both channels of the encoder, predicts the character stream and
// compares it character by character.
// ----------------------------------------------------------------------------
// Every accepted byte is encoded here into the characters it should release.
// The characters are queued in order, and each accepted output character is
// checked against the oldest one. The count of characters still due and the
// count of mismatches go to the testbench top.
// ----------------------------------------------------------------------------

module bubble_babble_encoder_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_digest_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       out_last_char,
  output int         mismatches,
  output int         chars_pending
);

  import bbe_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  enc_char_t  due_chars[$];

  // encoder state as the block should hold it
  int         check_sum;
  logic [7:0] half_byte;
  logic       have_half;
  logic       in_message;

  initial begin
    mismatches    = 0;
    chars_pending = 0;
  end

  function automatic logic [7:0] vowel_char(input int idx);
    string s;
    s = "aeiouy";
    return s[idx];
  endfunction

  function automatic logic [7:0] cons_char(input int idx);
    string s;
    s = "bcdfghklmnprstvzx";
    return s[idx];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_char(input logic [7:0] ch, input logic last);
    enc_char_t e;
    e.ch   = ch;
    e.last = last;
    due_chars.push_back(e);
  endtask

  task automatic push_triple(input logic [7:0] b, input int c);
    push_char(vowel_char((int'(b[7:6]) + c) % 6), 1'b0);
    push_char(cons_char(int'(b[5:2])), 1'b0);
    push_char(vowel_char((int'(b[1:0]) + c / 6) % 6), 1'b0);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [7:0] b0;
    int         c;
    c = check_sum;
    if (!in_message) begin
      push_char(CH_X, 1'b0);
      in_message = 1'b1;
    end
    if (!have_half) begin
      half_byte = b;
      have_half = 1'b1;
      if (!last) return;
      push_triple(b, c);
    end else begin
      b0 = half_byte;
      push_triple(b0, c);
      push_char(cons_char(int'(b[7:4])), 1'b0);
      push_char(CH_DASH, 1'b0);
      push_char(cons_char(int'(b[3:0])), 1'b0);
      c = (c * 5 + int'(b0) * 7 + int'(b)) % 36;
      check_sum = c;
      have_half = 1'b0;
      half_byte = 8'd0;
      if (!last) return;
      // even length: tail tuple built from the check alone
      push_char(vowel_char(c % 6), 1'b0);
      push_char(CH_X, 1'b0);
      push_char(vowel_char(c / 6), 1'b0);
    end
    push_char(CH_X, 1'b1);
    check_sum  = int'(CHECK_INIT);
    half_byte  = 8'd0;
    have_half  = 1'b0;
    in_message = 1'b0;
  endtask

  always @(posedge clk) begin
    enc_char_t e;
    if (!rst_n) begin
      check_sum  = int'(CHECK_INIT);
      half_byte  = 8'd0;
      have_half  = 1'b0;
      in_message = 1'b0;
      due_chars.delete();
    end else begin
      if (in_valid && !in_stall) encode_byte(in_digest_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (due_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    out_char, out_last_char));
        end else begin
          e = due_chars.pop_front();
          if (out_char !== e.ch)
            report_mismatch($sformatf("char 0x%02h, want 0x%02h", out_char, e.ch));
          if (out_last_char !== e.last)
            report_mismatch($sformatf("last_char %0b, want %0b on 0x%02h",
                                      out_last_char, e.last, e.ch));
        end
      end
    end
    chars_pending = due_chars.size();
  end

endmodule

@@ verif/bubble_babble_encoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bubble_babble_encoder_tb
// Stimulus and verdict for the Bubble Babble encoder.
// ----------------------------------------------------------------------------
// Sends directed messages (one byte, odd and even lengths, extreme byte
// values), drains, then sends random messages of random length. Both channels
// idle at random, with one long stretch at full rate. The checker beside the
// block predicts and compares every character.
// ----------------------------------------------------------------------------

module bubble_babble_encoder_tb;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_digest_byte = 8'd0;
  logic       in_last_byte   = 1'b0;
  logic       out_stall      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last_char;
  int         mismatches;
  int         chars_pending;
  bit         full_rate      = 1'b0;
  int         bytes_sent     = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bubble_babble_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_digest_byte (in_digest_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last_char  (out_last_char)
  );

  bubble_babble_encoder_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_digest_byte (in_digest_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .mismatches     (mismatches),
    .chars_pending  (chars_pending)
  );

  always @(posedge clk) begin
    out_stall <= !full_rate && ($urandom_range(99) < 22);
  end

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    logic stalled;
    while (!full_rate && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_digest_byte <= b;
    in_last_byte   <= last;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    bytes_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (chars_pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte messages at both extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    // even length
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    // odd length
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'ha5, 1'b1);
    // longer even message, check value wanders through several pairs
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h3c, 1'b1);
    // odd message with alternating bit patterns
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h01, 1'b1);

    wait_drained();

    while (bytes_sent < 145) begin
      full_rate = (bytes_sent >= 60 && bytes_sent < 110);
      if ($urandom_range(9) == 0) len = $urandom_range(32, 13);
      else len = $urandom_range(12, 1);
      send_message(len);
    end
    full_rate = 1'b0;

    in_valid <= 1'b0;
    do @(negedge clk); while (chars_pending != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
